// ===== sv/tsa_pkg.sv =====
// tsa_pkg: shared constants, codes and command/status structs of the tagged stack alu
// used by tsa_ctrl, tsa_dp and tagged_stack_alu; depends on nothing
package tsa_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int DATA_WIDTH  = 64;

  localparam int PTR_W    = $clog2(STACK_DEPTH);
  localparam int SP_W     = $clog2(STACK_DEPTH + 1);
  localparam int TAG_W    = 3;
  localparam int MODE_W   = 3;
  localparam int CNT_W    = 4;
  localparam int STATUS_W = 3;
  localparam int VAL_W    = 64;
  localparam int DEPTH_W  = 7;
  localparam int ENTRY_W  = TAG_W + DATA_WIDTH;
  localparam int MD_CNT_W = $clog2(DATA_WIDTH + 1);

  localparam logic [TAG_W-1:0] TAG_INT  = 3'd1;
  localparam logic [TAG_W-1:0] TAG_BOOL = 3'd4;
  localparam logic [TAG_W-1:0] TAG_PAIR = 3'd5;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH = 3'd0,
    MODE_ADD  = 3'd1,
    MODE_SUB  = 3'd2,
    MODE_MUL  = 3'd3,
    MODE_DIV  = 3'd4,
    MODE_EQ   = 3'd5,
    MODE_ZT   = 3'd6,
    MODE_NOP  = 3'd7
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_ARITY   = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_TYPE    = 3'd3,
    ST_FULL    = 3'd4,
    ST_DIVZERO = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    ACC_HOLD,
    ACC_INIT0,
    ACC_INIT1,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB,
    ACC_MUL,
    ACC_DIV,
    ACC_MDRES,
    ACC_SAVE,
    ACC_EQ,
    ACC_ZT
  } acc_op_t;

  typedef struct packed {
    logic    load_in;
    logic    pop_rd;
    logic    wr_push;
    logic    wr_res;
    logic    top_rd;
    logic    out_load;
    acc_op_t acc_op;
    status_t status;
  } tsa_cmd_t;

  typedef struct packed {
    logic sp_empty;
    logic sp_full;
    logic op_int;
    logic op_zt_ok;
    logic op_zero;
    logic md_done;
  } tsa_stat_t;

endpackage

// ===== sv/tsa_ram.sv =====
// tsa_ram: generic single write port, single read port ram with registered read
// no dependencies
module tsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/tsa_dp.sv =====
// tsa_dp: stack pointer, stack memory, accumulator, shared iterative mul/div, result register
// depends on tsa_pkg and tsa_ram
module tsa_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tsa_pkg::tsa_cmd_t             cmd,
  output tsa_pkg::tsa_stat_t            stat,
  input  logic [tsa_pkg::TAG_W-1:0]     in_push_tag,
  input  logic signed [tsa_pkg::VAL_W-1:0] in_push_value,
  output logic [tsa_pkg::STATUS_W-1:0]  out_status,
  output logic [tsa_pkg::TAG_W-1:0]     out_top_tag,
  output logic signed [tsa_pkg::VAL_W-1:0] out_top_value,
  output logic [tsa_pkg::DEPTH_W-1:0]   out_depth
);
  import tsa_pkg::*;

  logic [SP_W-1:0]       sp_r, sp_nxt, sp_m1;
  logic [TAG_W-1:0]      push_tag_r;
  logic [DATA_WIDTH-1:0] push_val_r;
  logic [DATA_WIDTH-1:0] acc_r, acc_nxt;
  logic [TAG_W-1:0]      res_tag_r, res_tag_nxt;
  logic [TAG_W-1:0]      sav_tag_r;
  logic [DATA_WIDTH-1:0] sav_val_r;

  logic                  ram_we, ram_re;
  logic [ENTRY_W-1:0]    ram_wdata, ram_rdata;
  logic [TAG_W-1:0]      rd_tag;
  logic [DATA_WIDTH-1:0] rd_val;

  // shared mul/div unit
  logic                  md_busy_r, md_busy_nxt;
  logic                  md_done_r, md_done_nxt;
  logic                  md_div_r, md_div_nxt;
  logic                  md_neg_r, md_neg_nxt;
  logic [MD_CNT_W-1:0]   md_cnt_r, md_cnt_nxt;
  logic [DATA_WIDTH-1:0] rem_r, rem_nxt;
  logic [DATA_WIDTH-1:0] quo_r, quo_nxt;
  logic [DATA_WIDTH-1:0] dvs_r, dvs_nxt;
  logic [DATA_WIDTH-1:0] prod_r, prod_nxt;
  logic [DATA_WIDTH:0]   shl, trial;
  logic [DATA_WIDTH-1:0] md_result, a_mag, b_mag;

  assign sp_m1 = sp_r - SP_W'(1);

  assign ram_we    = cmd.wr_push | cmd.wr_res;
  assign ram_re    = cmd.pop_rd | cmd.top_rd;
  assign ram_wdata = cmd.wr_push ? {push_tag_r, push_val_r} : {res_tag_r, acc_r};

  tsa_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (sp_r[PTR_W-1:0]),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (sp_m1[PTR_W-1:0]),
    .rdata (ram_rdata)
  );

  assign rd_tag = ram_rdata[ENTRY_W-1 -: TAG_W];
  assign rd_val = ram_rdata[DATA_WIDTH-1:0];

  assign stat.sp_empty = (sp_r == '0);
  assign stat.sp_full  = (sp_r == SP_W'(STACK_DEPTH));
  assign stat.op_int   = (rd_tag == TAG_INT);
  assign stat.op_zt_ok = (rd_tag == TAG_INT) || (rd_tag == TAG_PAIR);
  assign stat.op_zero  = (rd_val == '0);
  assign stat.md_done  = md_done_r;

  always_comb begin
    sp_nxt = sp_r;
    if (cmd.pop_rd) begin
      sp_nxt = sp_m1;
    end else if (ram_we) begin
      sp_nxt = sp_r + SP_W'(1);
    end
  end

  assign a_mag     = acc_r[DATA_WIDTH-1] ? (~acc_r + 1'b1) : acc_r;
  assign b_mag     = rd_val[DATA_WIDTH-1] ? (~rd_val + 1'b1) : rd_val;
  assign md_result = md_div_r ? (md_neg_r ? (~quo_r + 1'b1) : quo_r) : prod_r;

  always_comb begin
    acc_nxt     = acc_r;
    res_tag_nxt = res_tag_r;
    unique case (cmd.acc_op)
      ACC_HOLD:  acc_nxt = acc_r;
      ACC_INIT0: begin
        acc_nxt     = '0;
        res_tag_nxt = TAG_INT;
      end
      ACC_INIT1: begin
        acc_nxt     = DATA_WIDTH'(1);
        res_tag_nxt = TAG_INT;
      end
      ACC_LOAD:  acc_nxt = rd_val;
      ACC_ADD:   acc_nxt = acc_r + rd_val;
      ACC_SUB:   acc_nxt = acc_r - rd_val;
      ACC_MUL:   acc_nxt = acc_r;
      ACC_DIV:   acc_nxt = acc_r;
      ACC_MDRES: acc_nxt = md_result;
      ACC_SAVE:  acc_nxt = acc_r;
      ACC_EQ: begin
        acc_nxt     = DATA_WIDTH'((rd_tag == sav_tag_r) && (rd_val == sav_val_r));
        res_tag_nxt = TAG_BOOL;
      end
      ACC_ZT: begin
        acc_nxt     = DATA_WIDTH'(rd_val == '0);
        res_tag_nxt = TAG_BOOL;
      end
      default:   acc_nxt = acc_r;
    endcase
  end

  // one bit per cycle: shift-add multiply, restoring divide on magnitudes
  assign shl   = {rem_r, quo_r[DATA_WIDTH-1]};
  assign trial = shl - {1'b0, dvs_r};

  always_comb begin
    md_busy_nxt = md_busy_r;
    md_done_nxt = 1'b0;
    md_div_nxt  = md_div_r;
    md_neg_nxt  = md_neg_r;
    md_cnt_nxt  = md_cnt_r;
    rem_nxt     = rem_r;
    quo_nxt     = quo_r;
    dvs_nxt     = dvs_r;
    prod_nxt    = prod_r;
    if (cmd.acc_op == ACC_MUL) begin
      md_busy_nxt = 1'b1;
      md_div_nxt  = 1'b0;
      md_cnt_nxt  = MD_CNT_W'(DATA_WIDTH);
      dvs_nxt     = acc_r;
      quo_nxt     = rd_val;
      prod_nxt    = '0;
    end else if (cmd.acc_op == ACC_DIV) begin
      md_busy_nxt = 1'b1;
      md_div_nxt  = 1'b1;
      md_neg_nxt  = acc_r[DATA_WIDTH-1] ^ rd_val[DATA_WIDTH-1];
      md_cnt_nxt  = MD_CNT_W'(DATA_WIDTH);
      dvs_nxt     = b_mag;
      quo_nxt     = a_mag;
      rem_nxt     = '0;
    end else if (md_busy_r) begin
      md_cnt_nxt = md_cnt_r - MD_CNT_W'(1);
      if (md_cnt_r == MD_CNT_W'(1)) begin
        md_busy_nxt = 1'b0;
        md_done_nxt = 1'b1;
      end
      if (md_div_r) begin
        if (!trial[DATA_WIDTH]) begin
          rem_nxt = trial[DATA_WIDTH-1:0];
          quo_nxt = {quo_r[DATA_WIDTH-2:0], 1'b1};
        end else begin
          rem_nxt = shl[DATA_WIDTH-1:0];
          quo_nxt = {quo_r[DATA_WIDTH-2:0], 1'b0};
        end
      end else begin
        prod_nxt = quo_r[0] ? (prod_r + dvs_r) : prod_r;
        dvs_nxt  = dvs_r << 1;
        quo_nxt  = quo_r >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r      <= '0;
      md_busy_r <= 1'b0;
      md_done_r <= 1'b0;
      md_cnt_r  <= '0;
    end else begin
      sp_r      <= sp_nxt;
      md_busy_r <= md_busy_nxt;
      md_done_r <= md_done_nxt;
      md_cnt_r  <= md_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r     <= acc_nxt;
    res_tag_r <= res_tag_nxt;
    md_div_r  <= md_div_nxt;
    md_neg_r  <= md_neg_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    dvs_r     <= dvs_nxt;
    prod_r    <= prod_nxt;
    if (cmd.load_in) begin
      push_tag_r <= in_push_tag;
      push_val_r <= DATA_WIDTH'(in_push_value);
    end
    if (cmd.acc_op == ACC_SAVE) begin
      sav_tag_r <= rd_tag;
      sav_val_r <= rd_val;
    end
    if (cmd.out_load) begin
      out_status <= cmd.status;
      out_depth  <= DEPTH_W'(sp_r);
      if (sp_r == '0) begin
        out_top_tag   <= '0;
        out_top_value <= '0;
      end else begin
        out_top_tag   <= rd_tag;
        out_top_value <= VAL_W'($signed(rd_val));
      end
    end
  end

endmodule

// ===== sv/tsa_ctrl.sv =====
// tsa_ctrl: sequencer of the tagged stack alu, drives datapath commands and both handshakes
// depends on tsa_pkg
module tsa_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [tsa_pkg::MODE_W-1:0]  in_mode,
  input  logic [tsa_pkg::CNT_W-1:0]   in_arg_count,
  output logic                        out_valid,
  input  logic                        out_stall,
  output tsa_pkg::tsa_cmd_t           cmd,
  input  tsa_pkg::tsa_stat_t          stat
);
  import tsa_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DECODE = 8'b0000_0010,
    S_POP    = 8'b0000_0100,
    S_OPND   = 8'b0000_1000,
    S_BUSY   = 8'b0001_0000,
    S_PUSH   = 8'b0010_0000,
    S_FIN    = 8'b0100_0000,
    S_TOP    = 8'b1000_0000
  } state_t;

  state_t           state_r, state_nxt;
  mode_t            mode_r, mode_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             lead_r, lead_nxt;
  status_t          st_r, st_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt  = state_r;
    mode_nxt   = mode_r;
    cnt_nxt    = cnt_r;
    lead_nxt   = lead_r;
    st_nxt     = st_r;
    cmd        = '0;
    cmd.acc_op = ACC_HOLD;
    cmd.status = st_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt    = mode_t'(in_mode);
          cnt_nxt     = in_arg_count;
          cmd.load_in = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        st_nxt   = ST_OK;
        lead_nxt = 1'b0;
        unique case (mode_r)
          MODE_PUSH: begin
            if (stat.sp_full) begin
              st_nxt = ST_FULL;
            end else begin
              cmd.wr_push = 1'b1;
            end
            state_nxt = S_FIN;
          end
          MODE_ADD, MODE_MUL: begin
            cmd.acc_op = (mode_r == MODE_MUL) ? ACC_INIT1 : ACC_INIT0;
            state_nxt  = (cnt_r == '0) ? S_PUSH : S_POP;
          end
          MODE_SUB, MODE_DIV: begin
            if (cnt_r == '0) begin
              st_nxt    = ST_ARITY;
              state_nxt = S_FIN;
            end else begin
              cmd.acc_op = (mode_r == MODE_DIV) ? ACC_INIT1 : ACC_INIT0;
              lead_nxt   = (cnt_r > CNT_W'(1));
              state_nxt  = S_POP;
            end
          end
          MODE_EQ: begin
            if (cnt_r != CNT_W'(2)) begin
              st_nxt    = ST_ARITY;
              state_nxt = S_FIN;
            end else begin
              state_nxt = S_POP;
            end
          end
          MODE_ZT: begin
            if (cnt_r != CNT_W'(1)) begin
              st_nxt    = ST_ARITY;
              state_nxt = S_FIN;
            end else begin
              state_nxt = S_POP;
            end
          end
          MODE_NOP: state_nxt = S_FIN;
          default:  state_nxt = S_FIN;
        endcase
      end
      S_POP: begin
        if (stat.sp_empty) begin
          st_nxt    = ST_EMPTY;
          state_nxt = S_FIN;
        end else begin
          cmd.pop_rd = 1'b1;
          state_nxt  = S_OPND;
        end
      end
      S_OPND: begin
        cnt_nxt = cnt_r - CNT_W'(1);
        unique case (mode_r)
          MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV: begin
            if (!stat.op_int) begin
              st_nxt    = ST_TYPE;
              state_nxt = S_FIN;
            end else if (lead_r) begin
              cmd.acc_op = ACC_LOAD;
              lead_nxt   = 1'b0;
              state_nxt  = S_POP;
            end else if (mode_r == MODE_MUL) begin
              cmd.acc_op = ACC_MUL;
              state_nxt  = S_BUSY;
            end else if (mode_r == MODE_DIV) begin
              if (stat.op_zero) begin
                st_nxt    = ST_DIVZERO;
                state_nxt = S_FIN;
              end else begin
                cmd.acc_op = ACC_DIV;
                state_nxt  = S_BUSY;
              end
            end else begin
              cmd.acc_op = (mode_r == MODE_SUB) ? ACC_SUB : ACC_ADD;
              state_nxt  = (cnt_r == CNT_W'(1)) ? S_PUSH : S_POP;
            end
          end
          MODE_EQ: begin
            if (cnt_r == CNT_W'(2)) begin
              cmd.acc_op = ACC_SAVE;
              state_nxt  = S_POP;
            end else begin
              cmd.acc_op = ACC_EQ;
              state_nxt  = S_PUSH;
            end
          end
          MODE_ZT: begin
            if (!stat.op_zt_ok) begin
              st_nxt    = ST_TYPE;
              state_nxt = S_FIN;
            end else begin
              cmd.acc_op = ACC_ZT;
              state_nxt  = S_PUSH;
            end
          end
          default: state_nxt = S_FIN;
        endcase
      end
      S_BUSY: begin
        if (stat.md_done) begin
          cmd.acc_op = ACC_MDRES;
          state_nxt  = (cnt_r == '0) ? S_PUSH : S_POP;
        end
      end
      S_PUSH: begin
        if (stat.sp_full) begin
          st_nxt = ST_FULL;
        end else begin
          cmd.wr_res = 1'b1;
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.top_rd = 1'b1;
        state_nxt  = S_TOP;
      end
      S_TOP: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      st_r        <= ST_OK;
      lead_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      st_r        <= st_nxt;
      lead_r      <= lead_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;
    cnt_r  <= cnt_nxt;
  end

endmodule

// ===== sv/tagged_stack_alu.sv =====
// tagged_stack_alu: top level, joins the sequencer and the stack datapath
// depends on tsa_pkg, tsa_ctrl, tsa_dp (and tsa_ram through tsa_dp)
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------------
//  in_      | in_valid / in_stall    | in_mode, in_arg_count, in_push_tag, in_push_value
//  out_     | out_valid / out_stall  | out_status, out_top_tag, out_top_value, out_depth
//
// one request at a time; push, nop and arity errors go through decode and the top read
//   into the result register; each popped operand adds a memory read and a check;
//   multiply and divide also wait on the shared bit-serial unit for each folded operand
// the result register lets a new request be taken while the last result is still stalled
// synchronous active-low reset empties the stack; the stack memory itself is not cleared
module tagged_stack_alu (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [tsa_pkg::MODE_W-1:0]       in_mode,
  input  logic [tsa_pkg::CNT_W-1:0]        in_arg_count,
  input  logic [tsa_pkg::TAG_W-1:0]        in_push_tag,
  input  logic signed [tsa_pkg::VAL_W-1:0] in_push_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [tsa_pkg::STATUS_W-1:0]     out_status,
  output logic [tsa_pkg::TAG_W-1:0]        out_top_tag,
  output logic signed [tsa_pkg::VAL_W-1:0] out_top_value,
  output logic [tsa_pkg::DEPTH_W-1:0]      out_depth
);
  import tsa_pkg::*;

  // command and status between sequencer and datapath
  tsa_cmd_t  cmd;
  tsa_stat_t stat;

  tsa_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mode      (in_mode),
    .in_arg_count (in_arg_count),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cmd          (cmd),
    .stat         (stat)
  );

  tsa_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_push_tag   (in_push_tag),
    .in_push_value (in_push_value),
    .out_status    (out_status),
    .out_top_tag   (out_top_tag),
    .out_top_value (out_top_value),
    .out_depth     (out_depth)
  );

  // a taken request blocks the input until its result is formed
  a_req_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken twice in a row");

  // depth never goes past the stack size
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_depth <= DEPTH_W'(STACK_DEPTH)))
    else $error("reported depth beyond stack size");

  // empty stack reports a zero top
  a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_depth == '0) |-> (out_top_tag == '0 && out_top_value == '0))
    else $error("empty stack with non-zero top");

  // the mul/div unit only finishes while the sequencer waits for it
  a_md_done: assert property (@(posedge clk) disable iff (!rst_n)
    stat.md_done |-> (in_stall && !cmd.out_load))
    else $error("mul/div finished outside an operation");

endmodule

// ===== test/tagged_stack_alu_test.sv =====
// tagged_stack_alu_test: self-checking testbench of the tagged stack alu
// depends on tsa_pkg and tagged_stack_alu; directed table, full-stack and hold-off runs, then random phases
`timescale 1ns / 1ps

module tagged_stack_alu_test;
  import tsa_pkg::*;

  localparam int LIMIT = 12000000;
  localparam int N_RAND = 1800;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [MODE_W-1:0] in_mode = '0;
  logic [CNT_W-1:0] in_arg_count = '0;
  logic [TAG_W-1:0] in_push_tag = '0;
  logic signed [VAL_W-1:0] in_push_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [TAG_W-1:0] out_top_tag;
  logic signed [VAL_W-1:0] out_top_value;
  logic [DEPTH_W-1:0] out_depth;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TAG_W-1:0] tag;
    logic [VAL_W-1:0] value;
    logic [DEPTH_W-1:0] depth;
  } result_t;

  // one row of the directed table; chk set where the result is typed in
  typedef struct packed {
    mode_t mode;
    logic [CNT_W-1:0] cnt;
    logic [TAG_W-1:0] tag;
    logic [VAL_W-1:0] value;
    logic chk;
    result_t res;
  } row_t;

  // predictor state
  logic [TAG_W-1:0] stk_tag [STACK_DEPTH];
  logic [VAL_W-1:0] stk_val [STACK_DEPTH];
  int sp;

  result_t pending_results [$];
  int errors = 0;
  int cycles = 0;
  int send_idle = 0;  // percentage of idle cycles on the request side
  int recv_stall = 0; // percentage of stall cycles on the result side
  int hold_off = 0;   // cycles of forced receiver hold-off still to run

  tagged_stack_alu i_dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: random stall, plus the long hold-off when asked for
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall);
    end
  end

  // result checker
  always @(posedge clk) begin
    result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result status %0d depth %0d", $time, out_status, out_depth);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_status != exp_r.status) begin
          errors++;
          $display("%0t: status exp %0d got %0d", $time, exp_r.status, out_status);
        end
        if (out_top_tag != exp_r.tag) begin
          errors++;
          $display("%0t: top_tag exp %0d got %0d", $time, exp_r.tag, out_top_tag);
        end
        if (out_top_value != exp_r.value) begin
          errors++;
          $display("%0t: top_value exp %h got %h", $time, exp_r.value, out_top_value);
        end
        if (out_depth != exp_r.depth) begin
          errors++;
          $display("%0t: depth exp %0d got %0d", $time, exp_r.depth, out_depth);
        end
      end
    end
  end

  function automatic logic [VAL_W-1:0] div_trunc(logic signed [VAL_W-1:0] a,
                                                 logic signed [VAL_W-1:0] b);
    logic [VAL_W-1:0] ma, mb, q;
    ma = a[VAL_W-1] ? -a : a;
    mb = b[VAL_W-1] ? -b : b;
    q = ma / mb;
    return (a[VAL_W-1] != b[VAL_W-1]) ? -q : q;
  endfunction

  function automatic logic stack_push(logic [TAG_W-1:0] t, logic [VAL_W-1:0] v);
    if (sp >= STACK_DEPTH) return 1'b0;
    stk_tag[sp] = t;
    stk_val[sp] = v;
    sp++;
    return 1'b1;
  endfunction

  // pop into t/v; returns 0 on an empty stack
  function automatic logic stack_pop(output logic [TAG_W-1:0] t, output logic [VAL_W-1:0] v);
    if (sp == 0) return 1'b0;
    sp--;
    t = stk_tag[sp];
    v = stk_val[sp];
    return 1'b1;
  endfunction

  // fold over popped operands; operands popped before an error stay popped
  function automatic status_t fold_operands(mode_t m, int n);
    logic [VAL_W-1:0] acc, v;
    logic [TAG_W-1:0] t;
    int i;
    logic lead;
    acc = (m == MODE_MUL || m == MODE_DIV) ? 64'd1 : 64'd0;
    i = 0;
    lead = (m == MODE_SUB || m == MODE_DIV);
    if (lead && n < 1) return ST_ARITY;
    if (lead && n > 1) begin
      if (!stack_pop(t, v)) return ST_EMPTY;
      if (t != TAG_INT) return ST_TYPE;
      acc = v;
      i = 1;
    end
    for (; i < n; i++) begin
      if (!stack_pop(t, v)) return ST_EMPTY;
      if (t != TAG_INT) return ST_TYPE;
      case (m)
        MODE_ADD: acc = acc + v;
        MODE_SUB: acc = acc - v;
        MODE_MUL: acc = acc * v;
        default: begin
          if (v == 0) return ST_DIVZERO;
          acc = div_trunc(acc, v);
        end
      endcase
    end
    if (!stack_push(TAG_INT, acc)) return ST_FULL;
    return ST_OK;
  endfunction

  function automatic result_t predict_step(mode_t m, int n, logic [TAG_W-1:0] pt,
                                           logic [VAL_W-1:0] pv);
    status_t st;
    logic [TAG_W-1:0] t1, t2;
    logic [VAL_W-1:0] v1, v2;
    result_t r;
    st = ST_OK;
    case (m)
      MODE_PUSH: if (!stack_push(pt, pv)) st = ST_FULL;
      MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV: st = fold_operands(m, n);
      MODE_EQ: begin
        if (n != 2) st = ST_ARITY;
        else if (!stack_pop(t1, v1)) st = ST_EMPTY;
        else if (!stack_pop(t2, v2)) st = ST_EMPTY;
        else if (!stack_push(TAG_BOOL, (t1 == t2 && v1 == v2) ? 64'd1 : 64'd0)) st = ST_FULL;
      end
      MODE_ZT: begin
        if (n != 1) st = ST_ARITY;
        else if (!stack_pop(t1, v1)) st = ST_EMPTY;
        else if (t1 != TAG_INT && t1 != TAG_PAIR) st = ST_TYPE;
        else if (!stack_push(TAG_BOOL, (v1 == 0) ? 64'd1 : 64'd0)) st = ST_FULL;
      end
      default: ;
    endcase
    r.status = st;
    r.tag = (sp > 0) ? stk_tag[sp-1] : '0;
    r.value = (sp > 0) ? stk_val[sp-1] : '0;
    r.depth = DEPTH_W'(sp);
    return r;
  endfunction

  // offer one request and wait for acceptance; holds payload while stalled
  // valid stays up after acceptance until the next request or a drain
  task automatic send_request(mode_t m, logic [CNT_W-1:0] n, logic [TAG_W-1:0] t,
                              logic [VAL_W-1:0] v, logic chk, result_t typed);
    result_t r;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= m;
    in_arg_count <= n;
    in_push_tag <= t;
    in_push_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = predict_step(m, n, t, v);
    if (chk && r != typed) begin
      errors++;
      $display("%0t: table row exp %h predictor %h", $time, typed, r);
    end
    pending_results.push_back(r);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic result_t res(status_t s, logic [TAG_W-1:0] t, logic [VAL_W-1:0] v,
                                  int d);
    return {s, t, v, 7'(d)};
  endfunction

  localparam logic [VAL_W-1:0] MAXV = 64'h7fff_ffff_ffff_ffff;
  localparam logic [VAL_W-1:0] MINV = 64'h8000_0000_0000_0000;

  row_t dir_rows [$];

  // random operand: mostly small, sometimes extreme
  function automatic logic [VAL_W-1:0] rand_value;
    case ($urandom_range(5))
      0: return {$urandom, $urandom};
      1: return $urandom_range(1) ? MAXV : MINV;
      2: return -64'($urandom_range(3));
      default: return 64'($urandom_range(20));
    endcase
  endfunction

  // random request: pushes of mostly integers, primitives of mostly fitting arity
  task automatic send_random;
    mode_t m;
    int n;
    logic [TAG_W-1:0] t;
    int pick;
    pick = $urandom_range(99);
    if (pick < 45 || sp < 2) m = MODE_PUSH;
    else m = mode_t'($urandom_range(7));
    if (sp > STACK_DEPTH - 4 && $urandom_range(3) != 0) m = MODE_ADD;
    case (m)
      MODE_EQ: n = ($urandom_range(9) == 0) ? $urandom_range(15) : 2;
      MODE_ZT: n = ($urandom_range(9) == 0) ? $urandom_range(15) : 1;
      default: n = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(1, 3);
    endcase
    t = ($urandom_range(9) < 8) ? TAG_INT : 3'($urandom_range(7));
    send_request(m, CNT_W'(n), t, rand_value(), 1'b0, '0);
  endtask

  initial begin
    row_t rw;
    // directed table: extremes, every operation, the arity, empty, type and divide-by-zero cases
    dir_rows = '{
      '{MODE_NOP, 4'd0, 3'd0, 64'd0, 1'b1, res(ST_OK, 0, 0, 0)},
      '{MODE_ADD, 4'd1, 3'd0, 64'd0, 1'b1, res(ST_EMPTY, 0, 0, 0)},
      '{MODE_SUB, 4'd0, 3'd0, 64'd0, 1'b1, res(ST_ARITY, 0, 0, 0)},
      '{MODE_ADD, 4'd0, 3'd0, 64'd0, 1'b1, res(ST_OK, TAG_INT, 0, 1)},
      '{MODE_MUL, 4'd0, 3'd0, 64'd0, 1'b1, res(ST_OK, TAG_INT, 1, 2)},
      '{MODE_PUSH, 4'd15, 3'd7, MAXV, 1'b1, res(ST_OK, 3'd7, MAXV, 3)},
      '{MODE_ZT, 4'd1, 3'd0, 64'd0, 1'b1, res(ST_TYPE, TAG_INT, 1, 2)},
      '{MODE_PUSH, 4'd0, TAG_INT, MINV, 1'b1, res(ST_OK, TAG_INT, MINV, 3)},
      '{MODE_PUSH, 4'd0, TAG_INT, -64'd1, 1'b1, res(ST_OK, TAG_INT, -64'd1, 4)},
      '{MODE_DIV, 4'd2, 3'd0, 64'd0, 1'b0, res(ST_OK, 0, 0, 0)},
      '{MODE_PUSH, 4'd0, TAG_INT, 64'd0, 1'b1, res(ST_OK, TAG_INT, 0, 4)},
      '{MODE_DIV, 4'd2, 3'd0, 64'd0, 1'b1, res(ST_DIVZERO, TAG_INT, 1, 2)},
      '{MODE_SUB, 4'd1, 3'd0, 64'd0, 1'b0, res(ST_OK, 0, 0, 0)},
      '{MODE_DIV, 4'd1, 3'd0, 64'd0, 1'b0, res(ST_OK, 0, 0, 0)},
      '{MODE_PUSH, 4'd0, TAG_PAIR, 64'd0, 1'b0, res(ST_OK, 0, 0, 0)},
      '{MODE_ZT, 4'd1, 3'd0, 64'd0, 1'b1, res(ST_OK, TAG_BOOL, 1, 3)},
      '{MODE_EQ, 4'd3, 3'd0, 64'd0, 1'b1, res(ST_ARITY, TAG_BOOL, 1, 3)},
      '{MODE_EQ, 4'd2, 3'd0, 64'd0, 1'b0, res(ST_OK, 0, 0, 0)},
      '{MODE_PUSH, 4'd0, TAG_INT, 64'd5, 1'b0, res(ST_OK, 0, 0, 0)},
      '{MODE_PUSH, 4'd0, TAG_INT, 64'd5, 1'b0, res(ST_OK, 0, 0, 0)},
      '{MODE_EQ, 4'd2, 3'd0, 64'd0, 1'b0, res(ST_OK, 0, 0, 0)},
      '{MODE_MUL, 4'd15, 3'd0, 64'd0, 1'b0, res(ST_OK, 0, 0, 0)},
      '{MODE_SUB, 4'd1, 3'd0, 64'd0, 1'b1, res(ST_TYPE, TAG_INT, 0, 1)}
    };
    sp = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      rw = dir_rows[i];
      send_request(rw.mode, rw.cnt, rw.tag, rw.value, rw.chk, rw.res);
    end
    drain();

    // fill to full, then push on full, a zero-operand add on full and a 15-operand add
    while (sp < STACK_DEPTH) send_request(MODE_PUSH, 0, TAG_INT, rand_value(), 1'b0, '0);
    send_request(MODE_PUSH, 0, TAG_INT, 64'd0, 1'b0, '0);
    send_request(MODE_ADD, 0, 3'd0, 64'd0, 1'b0, '0);
    send_request(MODE_ADD, 15, 3'd0, 64'd0, 1'b0, '0);
    // sender pauses until every result has come
    drain();

    // long receiver hold-off while requests keep coming
    hold_off = 400;
    repeat (20) send_request(MODE_PUSH, 0, TAG_INT, rand_value(), 1'b0, '0);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 49; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 49; end
        default: begin send_idle = 9; recv_stall = 9; end
      endcase
      repeat (N_RAND / 4) send_random();
    end
    send_idle = 0;
    recv_stall = 0;
    drain();
    repeat (200) @(posedge clk);

    if (errors == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/tsa_pkg.sv
sv/tsa_ram.sv
sv/tsa_dp.sv
sv/tsa_ctrl.sv
sv/tagged_stack_alu.sv
test/tagged_stack_alu_test.sv
